### design/kms_pkg.sv
`timescale 1ns / 1ps
// Package for the keypad matrix scanner: constants, register indexes and
// the key decode function. No dependencies.
package kms_pkg;

  localparam int unsigned NUM_LINES = 8;
  localparam int unsigned LINE_W = $clog2(NUM_LINES);
  localparam int unsigned ROW_W = 8;
  localparam int unsigned DEB_W = 16;
  localparam int unsigned MASK_W = NUM_LINES;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned CFG_DATA_W = DEB_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ROW_W-1:0] ALL_HIGH = 8'hFF;
  localparam logic [CODE_W-1:0] PAIR_BASE = 8'd101;
  localparam logic [CODE_W-1:0] CODE_MAX = 8'd128;
  localparam logic [CODE_W-1:0] SINGLE_MAX = 8'd64;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd15;
  localparam logic [MASK_W-1:0] PAIR_MASK_RST = 8'h02;
  localparam logic [ROW_W-1:0] LAST_LINE_DRIVE = 8'h7F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 1'b0,
    CFG_PAIR_MASK = 1'b1
  } cfg_idx_t;

  // offset of the first pair whose lower row is a (lexicographic numbering)
  function automatic logic [4:0] pair_offset(input logic [2:0] a);
    logic [4:0] off;
    unique case (a)
      3'd0: off = 5'd0;
      3'd1: off = 5'd7;
      3'd2: off = 5'd13;
      3'd3: off = 5'd18;
      3'd4: off = 5'd22;
      3'd5: off = 5'd25;
      3'd6: off = 5'd27;
      default: off = 5'd28;
    endcase
    return off;
  endfunction

  function automatic logic [CODE_W-1:0] decode_key(
    input logic [LINE_W-1:0] line,
    input logic [ROW_W-1:0]  levels,
    input logic              pair_en
  );
    logic [ROW_W-1:0] pressed;
    logic [3:0]       cnt;
    logic [2:0]       first;
    logic [2:0]       second;
    logic [4:0]       idx;
    logic [CODE_W-1:0] code;
    pressed = ~levels;
    cnt = '0;
    first = '0;
    second = '0;
    for (int r = 0; r < ROW_W; r++) begin
      if (pressed[r]) begin
        if (cnt == 4'd0) first = 3'(r);
        else if (cnt == 4'd1) second = 3'(r);
        cnt = cnt + 4'd1;
      end
    end
    idx = pair_offset(first) + 5'(second - first - 3'd1);
    if (cnt == 4'd1) begin
      code = {2'b00, line, first} + 8'd1;
    end else if (cnt == 4'd2 && pair_en) begin
      code = PAIR_BASE + {3'b000, idx};
    end else begin
      code = '0;
    end
    return code;
  endfunction

endpackage

### design/kms_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the keypad matrix scanner.
// Depends on kms_pkg for field widths.
interface kms_in_if;
  logic                     valid;
  logic                     ready;
  logic [kms_pkg::ROW_W-1:0] row_levels;
  modport source (output valid, output row_levels, input ready);
  modport sink   (input valid, input row_levels, output ready);
endinterface

interface kms_out_if;
  logic                      valid;
  logic                      ready;
  logic [kms_pkg::ROW_W-1:0]  drive_lines;
  logic                      scan_done;
  logic [kms_pkg::CODE_W-1:0] key_code;
  modport source (output valid, output drive_lines, output scan_done, output key_code,
                  input ready);
  modport sink   (input valid, input drive_lines, input scan_done, input key_code,
                  output ready);
endinterface

### design/keypad_matrix_scanner.sv
`timescale 1ns / 1ps
// Keypad matrix scanner top level: input register, scan/debounce/decode step, result register.
// Depends on kms_pkg and the channel interfaces in kms_if.sv.
//
// Each item is one sampled tick of the 8 return lines and yields exactly one result
// item: the scan line driven for that sample, scan_done, and key_code (nonzero only
// with scan_done). One item per cycle is sustained while results are taken. An accepted
// item sits in the input register, is decoded and loaded into the result register, and
// its result is then offered on the output channel. A stalled result stalls the input
// only when both registers are full.
module keypad_matrix_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  kms_in_if.sink                          in_ch,
  kms_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [kms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kms_pkg::*;

  logic [DEB_W-1:0]  debounce_r;
  logic [MASK_W-1:0] pair_mask_r;

  logic              s1_v_r;
  logic [ROW_W-1:0]  s1_levels_r;
  logic              s1_move;

  logic [LINE_W-1:0] line_r, line_nxt;
  logic              deb_r, deb_nxt;
  logic [DEB_W-1:0]  wait_r, wait_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;

  logic              out_v_r;
  logic [ROW_W-1:0]  drive_r, drive_nxt;
  logic              done_r, done_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  logic              advance;
  logic [CODE_W-1:0] held_cur;

  assign s1_move = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      pair_mask_r <= PAIR_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:  debounce_r  <= cfg_data;
        CFG_PAIR_MASK: pair_mask_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    line_nxt  = line_r;
    deb_nxt   = deb_r;
    wait_nxt  = wait_r;
    held_cur  = held_r;
    advance   = 1'b0;
    drive_nxt = ~(ROW_W'(1) << line_r);
    done_nxt  = 1'b0;
    code_nxt  = '0;
    if (!deb_r) begin
      if (s1_levels_r != ALL_HIGH) begin
        deb_nxt  = 1'b1;
        wait_nxt = debounce_r;
      end else begin
        advance = 1'b1;
      end
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - DEB_W'(1);
    end else begin
      if (s1_levels_r != ALL_HIGH)
        held_cur = decode_key(line_r, s1_levels_r, pair_mask_r[line_r]);
      deb_nxt = 1'b0;
      advance = 1'b1;
    end
    held_nxt = held_cur;
    if (advance) begin
      if (line_r == LINE_W'(NUM_LINES - 1)) begin
        done_nxt = 1'b1;
        code_nxt = held_cur;
        held_nxt = '0;
        line_nxt = '0;
      end else begin
        line_nxt = line_r + LINE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      line_r  <= '0;
      deb_r   <= 1'b0;
      wait_r  <= '0;
      held_r  <= '0;
    end else begin
      if (in_ch.ready) s1_v_r <= in_ch.valid;
      if (s1_move) begin
        out_v_r <= 1'b1;
        line_r  <= line_nxt;
        deb_r   <= deb_nxt;
        wait_r  <= wait_nxt;
        held_r  <= held_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) s1_levels_r <= in_ch.row_levels;
    if (s1_move) begin
      drive_r <= drive_nxt;
      done_r  <= done_nxt;
      code_r  <= code_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.drive_lines = drive_r;
  assign out_ch.scan_done   = done_r;
  assign out_ch.key_code    = code_r;

endmodule

### design/kms_checker.sv
`timescale 1ns / 1ps
// Port-level checks for keypad_matrix_scanner, attached by bind.
// Depends on kms_pkg.
module kms_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [kms_pkg::ROW_W-1:0]  out_drive_lines,
  input logic                       out_scan_done,
  input logic [kms_pkg::CODE_W-1:0] out_key_code
);
  import kms_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_code)
      && $stable(out_drive_lines) && $stable(out_scan_done))
    else $error("result item changed while stalled");

  a_code_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_scan_done |-> out_key_code == '0)
    else $error("key code outside scan end");

  a_done_on_last_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_done |-> out_drive_lines == LAST_LINE_DRIVE)
    else $error("scan end not on last line");

  a_one_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(~out_drive_lines) == 1)
    else $error("drive pattern not a single low line");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_code <= SINGLE_MAX
      || (out_key_code >= PAIR_BASE && out_key_code <= CODE_MAX))
    else $error("key code out of range");

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_drive_lines (out_ch.drive_lines),
  .out_scan_done   (out_ch.scan_done),
  .out_key_code    (out_ch.key_code)
);
